// ===== hw/rtl/quad_reload_timer_block_top_macros.svh =====
// Assertion macros shared by the timer block RTL.
`ifndef QUAD_RELOAD_TIMER_BLOCK_TOP_MACROS_SVH
`define QUAD_RELOAD_TIMER_BLOCK_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define QRT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define QRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define QRT_ASSERT_SAME(lbl, ante, cons, msg)

`define QRT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/qrt_pkg.sv =====
// Types, register map constants and helper functions of the quad reload timer block.
`default_nettype none

package qrt_pkg;

   localparam int MAX_TIMERS = 4;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      VAR_WRITE  = 2'd0,
      VAR_SET    = 2'd1,
      VAR_CLEAR  = 2'd2,
      VAR_TOGGLE = 2'd3
   } var_type;

   localparam logic [8:0] REG_ROT        = 9'h000;
   localparam logic [8:0] REG_FIRST_TMR  = 9'h002;
   localparam logic [8:0] REG_LAST_TMR   = 9'h009;
   localparam logic [8:0] REG_VERSION    = 9'h00a;

   localparam logic [31:0] VERSION_VALUE  = 32'h0101_0000;
   localparam logic [31:0] ROT_FIXED      = 32'h1e00_0000;
   localparam logic [31:0] ROT_SFTRST     = 32'h8000_0000;
   localparam logic [31:0] ROT_CLKGATE    = 32'h4000_0000;

   localparam int CTRL_IRQ_BIT    = 15;
   localparam int CTRL_IRQ_EN_BIT = 14;
   localparam int CTRL_RELOAD_BIT = 6;

   localparam logic [3:0] SEL_32K = 4'h8;
   localparam logic [3:0] SEL_8K  = 4'h9;
   localparam logic [3:0] SEL_4K  = 4'ha;
   localparam logic [3:0] SEL_1K  = 4'hc;

   typedef struct packed {
      logic        wr_ctrl;
      logic        wr_cnt;
      logic        tick;
      var_type     variant;
      logic [15:0] wdata;
   } qrt_cmd_type;

   function automatic logic rate_valid(input logic [3:0] sel);
      logic ok;
      case (sel)
         SEL_32K, SEL_8K, SEL_4K, SEL_1K: ok = 1'b1;
         default:                         ok = 1'b0;
      endcase
      return ok;
   endfunction

   // last divider value before a count step
   function automatic logic [4:0] rate_last(input logic [3:0] sel);
      logic [4:0] last;
      case (sel)
         SEL_32K: last = 5'd0;
         SEL_8K:  last = 5'd3;
         SEL_4K:  last = 5'd7;
         SEL_1K:  last = 5'd31;
         default: last = 5'd0;
      endcase
      return last;
   endfunction

   function automatic logic [15:0] apply_variant16(input logic [15:0] old,
                                                   input var_type    variant,
                                                   input logic [15:0] v);
      logic [15:0] res;
      case (variant)
         VAR_SET:    res = old | v;
         VAR_CLEAR:  res = old & ~v;
         VAR_TOGGLE: res = old ^ v;
         default:    res = v;
      endcase
      return res;
   endfunction

   function automatic logic [31:0] apply_variant32(input logic [31:0] old,
                                                   input var_type    variant,
                                                   input logic [31:0] v);
      logic [31:0] res;
      case (variant)
         VAR_SET:    res = old | v;
         VAR_CLEAR:  res = old & ~v;
         VAR_TOGGLE: res = old ^ v;
         default:    res = v;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/qrt_timer.sv =====
// One reload down-counter with its control register, divider and interrupt line.
`default_nettype none
`include "quad_reload_timer_block_top_macros.svh"

module qrt_timer
   import qrt_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  qrt_cmd_type            cmd,
   output logic [15:0]            ctrl,
   output logic [COUNT_WIDTH-1:0] fixed_count,
   output logic [COUNT_WIDTH-1:0] current_count,
   output logic                   irq_next
);

   logic [15:0]            ctrl_ff,    ctrl_in;
   logic [COUNT_WIDTH-1:0] fixed_ff,   fixed_in;
   logic [COUNT_WIDTH-1:0] cur_ff,     cur_in;
   logic                   running_ff, running_in;
   logic                   fired_ff,   fired_in;
   logic                   irq_ff,     irq_in;
   logic [4:0]             div_ff,     div_in;

   logic [15:0]            ctrl_new;
   logic [15:0]            cnt_wide;
   logic [COUNT_WIDTH-1:0] cnt_new;
   logic                   fixed_nz;

   assign ctrl_new = apply_variant16(ctrl_ff, cmd.variant, cmd.wdata);
   assign cnt_wide = apply_variant16(16'(fixed_ff), cmd.variant, cmd.wdata);
   assign cnt_new  = cnt_wide[COUNT_WIDTH-1:0];
   assign fixed_nz = (fixed_ff != '0);

   always_comb begin
      ctrl_in    = ctrl_ff;
      fixed_in   = fixed_ff;
      cur_in     = cur_ff;
      running_in = running_ff;
      fired_in   = fired_ff;
      irq_in     = irq_ff;
      div_in     = div_ff;
      if (cmd.wr_ctrl) begin
         if (ctrl_new != ctrl_ff) begin
            if (!ctrl_new[CTRL_IRQ_BIT]) begin
               irq_in = 1'b0;
            end
            if (!rate_valid(ctrl_new[3:0])) begin
               running_in = 1'b0;
            end else if (ctrl_new[7:0] != ctrl_ff[7:0]) begin
               // restart from the written count
               cur_in = fixed_ff;
               div_in = '0;
               if (fixed_nz) begin
                  fired_in   = 1'b0;
                  running_in = 1'b1;
               end else begin
                  running_in = 1'b0;
               end
            end
            ctrl_in = ctrl_new;
         end
      end else if (cmd.wr_cnt) begin
         if ((cnt_new != fixed_ff) || fired_ff) begin
            fixed_in = cnt_new;
            cur_in   = cnt_new;
            div_in   = '0;
            if (cnt_new != '0) begin
               fired_in   = 1'b0;
               running_in = rate_valid(ctrl_ff[3:0]);
            end else begin
               running_in = 1'b0;
            end
         end
      end else if (cmd.tick) begin
         if (running_ff && rate_valid(ctrl_ff[3:0])) begin
            if (div_ff < rate_last(ctrl_ff[3:0])) begin
               div_in = div_ff + 5'd1;
            end else begin
               div_in = '0;
               if (cur_ff <= COUNT_WIDTH'(1)) begin
                  // expire: flag, status bit, line, then reload or stop
                  fired_in = 1'b1;
                  ctrl_in  = ctrl_ff | 16'(1 << CTRL_IRQ_BIT);
                  if (ctrl_ff[CTRL_IRQ_EN_BIT]) begin
                     irq_in = 1'b1;
                  end
                  if (ctrl_ff[CTRL_RELOAD_BIT] && fixed_nz) begin
                     cur_in = fixed_ff;
                  end else begin
                     cur_in     = '0;
                     running_in = 1'b0;
                  end
               end else begin
                  cur_in = cur_ff - COUNT_WIDTH'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= '0;
         fixed_ff   <= '0;
         cur_ff     <= '0;
         running_ff <= 1'b0;
         fired_ff   <= 1'b0;
         irq_ff     <= 1'b0;
         div_ff     <= '0;
      end else begin
         ctrl_ff    <= ctrl_in;
         fixed_ff   <= fixed_in;
         cur_ff     <= cur_in;
         running_ff <= running_in;
         fired_ff   <= fired_in;
         irq_ff     <= irq_in;
         div_ff     <= div_in;
      end
   end

   assign ctrl          = ctrl_ff;
   assign fixed_count   = fixed_ff;
   assign current_count = cur_ff;
   assign irq_next      = irq_in;

   `QRT_ASSERT_SAME(a_run_needs_rate, running_ff, rate_valid(ctrl_ff[3:0]) && (cur_ff != '0), "running timer without rate or count")
   `QRT_ASSERT_SAME(a_div_in_range, running_ff, div_ff <= rate_last(ctrl_ff[3:0]), "divider past its rate")
   `QRT_ASSERT_SAME(a_line_has_status, irq_ff, ctrl_ff[CTRL_IRQ_BIT], "line high with status clear")

endmodule

`default_nettype wire

// ===== hw/rtl/quad_reload_timer_block_top.sv =====
// Top level of the quad reload timer block: input stage, register decode, timers, result stage.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid/req_ready, op, addr, wdata    | in
//   rsp     | rsp_valid/rsp_ready, rdata, irq_lines,  | out
//           | bad_offset                              |
//
// One transaction enters per cycle while req_ready is high; it passes the input register,
// then decode and timer update into the result register.
// Throughput is one transaction per cycle unless stalled, set by the single update pass per timer.
// Synchronous reset clears both stage valids, the rotary control and all timer state.
// A stalled result holds both stages; req_ready follows rsp_ready when both are full.
`default_nettype none
`include "quad_reload_timer_block_top_macros.svh"

module quad_reload_timer_block_top
   import qrt_pkg::*;
#(
   parameter int NUM_TIMERS  = 4,
   parameter int COUNT_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [12:0] req_addr,
   input  logic [31:0] req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_rdata,
   output logic [3:0]  rsp_irq_lines,
   output logic        rsp_bad_offset
);

   localparam logic [3:0] LINE_MASK = 4'((1 << NUM_TIMERS) - 1);

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic [12:0] s1_addr_ff;
   logic [31:0] s1_wdata_ff;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_rdata_ff, rsp_rdata_in;
   logic [3:0]  rsp_lines_ff, rsp_lines_in;
   logic        rsp_bad_ff,   rsp_bad_in;

   logic [31:0] rot_ff, rot_in;

   logic        s2_load;
   logic        fire;
   logic [8:0]  reg_idx;
   logic [8:0]  reg_m2;
   logic [1:0]  tid;
   logic        tmr_range;
   logic        tid_ok;
   logic        ctrl_hit;
   logic        cnt_hit;
   var_type     variant;
   logic [31:0] rot_new;

   logic [15:0] ctrl_arr  [MAX_TIMERS];
   logic [15:0] fixed_arr [MAX_TIMERS];
   logic [15:0] cur_arr   [MAX_TIMERS];
   logic [3:0]  irq_next_vec;

   assign s2_load     = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !s1_valid_ff || s2_load;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;
   assign fire        = s1_valid_ff && s2_load;

   assign reg_idx   = s1_addr_ff[12:4];
   assign reg_m2    = reg_idx - REG_FIRST_TMR;
   assign tid       = reg_m2[2:1];
   assign tmr_range = (reg_idx >= REG_FIRST_TMR) && (reg_idx <= REG_LAST_TMR);
   assign tid_ok    = int'(tid) < NUM_TIMERS;
   assign ctrl_hit  = tmr_range && !reg_idx[0] && tid_ok;
   assign cnt_hit   = tmr_range && reg_idx[0] && tid_ok;
   assign variant   = var_type'(s1_addr_ff[3:2]);

   always_comb begin
      rot_new = apply_variant32(rot_ff, variant, s1_wdata_ff);
      // soft reset rising alone also gates the clock
      if (((rot_ff ^ rot_new) == ROT_SFTRST) && ((rot_ff & ROT_SFTRST) == '0)) begin
         rot_new = rot_new | ROT_CLKGATE;
      end
   end

   always_comb begin
      rsp_rdata_in = '0;
      rsp_bad_in   = 1'b0;
      rot_in       = rot_ff;
      unique case (s1_op_ff)
         OP_READ: begin
            if (reg_idx == REG_ROT) begin
               rsp_rdata_in = rot_ff | ROT_FIXED;
            end else if (reg_idx == REG_VERSION) begin
               rsp_rdata_in = VERSION_VALUE;
            end else if (ctrl_hit) begin
               rsp_rdata_in = {16'h0000, ctrl_arr[tid]};
            end else if (cnt_hit) begin
               rsp_rdata_in = {cur_arr[tid], fixed_arr[tid]};
            end else begin
               rsp_bad_in = 1'b1;
            end
         end
         OP_WRITE: begin
            if (reg_idx == REG_ROT) begin
               if (fire) begin
                  rot_in = rot_new | ROT_FIXED;
               end
            end else if (!ctrl_hit && !cnt_hit) begin
               rsp_bad_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_lines_in = irq_next_vec;
      rsp_valid_in = s2_load ? s1_valid_ff : rsp_valid_ff;
   end

   for (genvar t = 0; t < MAX_TIMERS; t++) begin : g_tmr
      if (t < NUM_TIMERS) begin : g_on
         qrt_cmd_type            cmd;
         logic [COUNT_WIDTH-1:0] fixed_cnt;
         logic [COUNT_WIDTH-1:0] cur_cnt;

         assign cmd.wr_ctrl = fire && (s1_op_ff == OP_WRITE) && ctrl_hit && (int'(tid) == t);
         assign cmd.wr_cnt  = fire && (s1_op_ff == OP_WRITE) && cnt_hit && (int'(tid) == t);
         assign cmd.tick    = fire && (s1_op_ff == OP_TICK);
         assign cmd.variant = variant;
         assign cmd.wdata   = s1_wdata_ff[15:0];

         qrt_timer #(
            .COUNT_WIDTH (COUNT_WIDTH)
         ) u_timer (
            .clock         (clock),
            .reset         (reset),
            .cmd           (cmd),
            .ctrl          (ctrl_arr[t]),
            .fixed_count   (fixed_cnt),
            .current_count (cur_cnt),
            .irq_next      (irq_next_vec[t])
         );

         assign fixed_arr[t] = 16'(fixed_cnt);
         assign cur_arr[t]   = 16'(cur_cnt);
      end else begin : g_off
         assign ctrl_arr[t]     = '0;
         assign fixed_arr[t]    = '0;
         assign cur_arr[t]      = '0;
         assign irq_next_vec[t] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rot_ff       <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rot_ff       <= rot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_op_ff    <= req_op;
         s1_addr_ff  <= req_addr;
         s1_wdata_ff <= req_wdata;
      end
      if (fire) begin
         rsp_rdata_ff <= rsp_rdata_in;
         rsp_lines_ff <= rsp_lines_in;
         rsp_bad_ff   <= rsp_bad_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rdata      = rsp_rdata_ff;
   assign rsp_irq_lines  = rsp_lines_ff;
   assign rsp_bad_offset = rsp_bad_ff;

   `QRT_ASSERT_NEXT(a_fire_gives_rsp, fire, rsp_valid, "advanced transaction lost")
   `QRT_ASSERT_SAME(a_bad_reads_zero, rsp_valid && rsp_bad_offset, rsp_rdata == '0, "unmapped access with data")
   `QRT_ASSERT_SAME(a_lines_in_range, rsp_valid, (rsp_irq_lines & ~LINE_MASK) == '0, "line of absent timer high")

endmodule

`default_nettype wire
